// File: src/mcpg_pkg.sv
// ----------------------------------------------------------------------------
// mcpg_pkg
// shared types and constants of the midpoint circle point generator
// ----------------------------------------------------------------------------
package mcpg_pkg;

  localparam int unsigned POINTS_PER_STEP = 8;
  localparam int unsigned IDX_W           = $clog2(POINTS_PER_STEP);
  localparam int unsigned COORD_W         = 16;
  localparam int unsigned POINT_W         = 17;
  localparam int unsigned RADIUS_W        = 14;
  localparam int unsigned DIAM_W          = RADIUS_W + 1;
  localparam int unsigned CUR_Y_W         = 15;
  localparam int unsigned STEP_W          = 17;
  localparam int unsigned DEC_W           = 18;
  localparam int unsigned COLOR_W         = 32;
  localparam int unsigned QUEUE_DEPTH     = 2;
  localparam int unsigned QPTR_W          = $clog2(QUEUE_DEPTH);

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_STEP  = 1'b1;

  // one queued job: either eight mirrored points or a finished marker
  typedef struct packed {
    logic                       fin;
    logic signed [COORD_W-1:0]  cx;
    logic signed [COORD_W-1:0]  cy;
    logic signed [COORD_W-1:0]  x;
    logic        [CUR_Y_W-1:0]  y;
    logic        [COLOR_W-1:0]  color;
  } job_t;

endpackage

// File: src/mcpg_ifs.sv
// ----------------------------------------------------------------------------
// mcpg request channels
// valid/ready channels carrying circle requests and plotted points
// ----------------------------------------------------------------------------
interface mcpg_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic signed [15:0] center_x;
  logic signed [15:0] center_y;
  logic [13:0] radius;
  logic [31:0] color;

  modport source (output valid, kind, center_x, center_y, radius, color, input ready);
  modport sink   (input valid, kind, center_x, center_y, radius, color, output ready);
endinterface

interface mcpg_out_if;
  logic        valid;
  logic        ready;
  logic signed [16:0] point_x;
  logic signed [16:0] point_y;
  logic [31:0] point_color;
  logic        last_of_step;
  logic        finished;

  modport source (output valid, point_x, point_y, point_color, last_of_step, finished,
                  input ready);
  modport sink   (input valid, point_x, point_y, point_color, last_of_step, finished,
                  output ready);
endinterface

// File: src/mcpg_front.sv
// ----------------------------------------------------------------------------
// mcpg_front
// accepts requests, runs the midpoint iteration and queues point jobs
// ----------------------------------------------------------------------------
module mcpg_front (
  input  logic                 clk,
  input  logic                 rst_n,
  mcpg_in_if.sink              in_chan,
  input  logic                 q_full,
  output logic                 q_push,
  output mcpg_pkg::job_t       q_job
);

  logic                                       active_r, active_nxt;
  logic signed [mcpg_pkg::COORD_W-1:0]        cur_x_r, cur_x_nxt;
  logic        [mcpg_pkg::CUR_Y_W-1:0]        cur_y_r, cur_y_nxt;
  logic        [mcpg_pkg::STEP_W-1:0]         step_x_r, step_x_nxt;
  logic        [mcpg_pkg::STEP_W-1:0]         step_y_r, step_y_nxt;
  logic signed [mcpg_pkg::DEC_W-1:0]          dec_r, dec_nxt;
  logic        [mcpg_pkg::DIAM_W-1:0]         diam_r, diam_nxt;
  logic signed [mcpg_pkg::COORD_W-1:0]        org_x_r, org_x_nxt;
  logic signed [mcpg_pkg::COORD_W-1:0]        org_y_r, org_y_nxt;
  logic        [mcpg_pkg::COLOR_W-1:0]        color_r, color_nxt;

  logic                                       accept;
  logic                                       done;
  logic signed [mcpg_pkg::DEC_W-1:0]          dec_a, dec_b;
  logic        [mcpg_pkg::CUR_Y_W-1:0]        y_a;
  logic        [mcpg_pkg::STEP_W-1:0]         sy_a, sx_b;
  logic        [mcpg_pkg::DIAM_W-1:0]         start_diam;

  assign in_chan.ready = !q_full;
  assign accept        = in_chan.valid && !q_full;

  assign done = !active_r ||
                ($signed({cur_x_r[mcpg_pkg::COORD_W-1], cur_x_r}) <
                 $signed({2'b00, cur_y_r}));

  always_comb begin
    // first test: advance y
    if (dec_r <= 0) begin
      dec_a = dec_r + $signed({1'b0, step_y_r});
      y_a   = cur_y_r + 1'b1;
      sy_a  = step_y_r + mcpg_pkg::STEP_W'(2);
    end else begin
      dec_a = dec_r;
      y_a   = cur_y_r;
      sy_a  = step_y_r;
    end
    // second test on the new error: pull x in
    sx_b  = step_x_r + mcpg_pkg::STEP_W'(2);
    dec_b = dec_a + $signed({1'b0, sx_b}) - $signed({3'b000, diam_r});
    start_diam = {in_chan.radius, 1'b0};

    active_nxt  = active_r;
    cur_x_nxt   = cur_x_r;
    cur_y_nxt   = cur_y_r;
    step_x_nxt  = step_x_r;
    step_y_nxt  = step_y_r;
    dec_nxt     = dec_r;
    diam_nxt    = diam_r;
    org_x_nxt   = org_x_r;
    org_y_nxt   = org_y_r;
    color_nxt   = color_r;
    q_push      = 1'b0;

    q_job.fin   = done;
    q_job.cx    = org_x_r;
    q_job.cy    = org_y_r;
    q_job.x     = cur_x_r;
    q_job.y     = cur_y_r;
    q_job.color = color_r;

    if (accept) begin
      if (in_chan.kind == mcpg_pkg::KIND_START) begin
        active_nxt = 1'b1;
        org_x_nxt  = in_chan.center_x;
        org_y_nxt  = in_chan.center_y;
        color_nxt  = in_chan.color;
        diam_nxt   = start_diam;
        cur_x_nxt  = $signed({2'b00, in_chan.radius}) - mcpg_pkg::COORD_W'(1);
        cur_y_nxt  = '0;
        step_x_nxt = mcpg_pkg::STEP_W'(1);
        step_y_nxt = mcpg_pkg::STEP_W'(1);
        dec_nxt    = mcpg_pkg::DEC_W'(1) - $signed({3'b000, start_diam});
      end else begin
        q_push = 1'b1;
        if (done) begin
          active_nxt = 1'b0;
        end else begin
          cur_y_nxt  = y_a;
          step_y_nxt = sy_a;
          if (dec_a > 0) begin
            cur_x_nxt  = cur_x_r - mcpg_pkg::COORD_W'(1);
            step_x_nxt = sx_b;
            dec_nxt    = dec_b;
          end else begin
            dec_nxt    = dec_a;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      cur_x_r  <= '0;
      cur_y_r  <= '0;
      step_x_r <= '0;
      step_y_r <= '0;
      dec_r    <= '0;
      diam_r   <= '0;
      org_x_r  <= '0;
      org_y_r  <= '0;
      color_r  <= '0;
    end else begin
      active_r <= active_nxt;
      cur_x_r  <= cur_x_nxt;
      cur_y_r  <= cur_y_nxt;
      step_x_r <= step_x_nxt;
      step_y_r <= step_y_nxt;
      dec_r    <= dec_nxt;
      diam_r   <= diam_nxt;
      org_x_r  <= org_x_nxt;
      org_y_r  <= org_y_nxt;
      color_r  <= color_nxt;
    end
  end

endmodule

// File: src/mcpg_queue.sv
// ----------------------------------------------------------------------------
// mcpg_queue
// short job queue decoupling the iteration from point output
// ----------------------------------------------------------------------------
module mcpg_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  mcpg_pkg::job_t push_job,
  input  logic           pop,
  output logic           full,
  output logic           not_empty,
  output mcpg_pkg::job_t head_job
);

  mcpg_pkg::job_t                   slot_r [mcpg_pkg::QUEUE_DEPTH];
  logic [mcpg_pkg::QPTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [mcpg_pkg::QPTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [mcpg_pkg::QPTR_W:0]        count_r, count_nxt;

  assign full      = (count_r == (mcpg_pkg::QPTR_W+1)'(mcpg_pkg::QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign head_job  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// File: src/mcpg_back.sv
// ----------------------------------------------------------------------------
// mcpg_back
// walks the eight octant mirrors of a job into the output register
// ----------------------------------------------------------------------------
module mcpg_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_not_empty,
  input  mcpg_pkg::job_t head_job,
  output logic           q_pop,
  mcpg_out_if.source     out_chan
);

  logic [mcpg_pkg::IDX_W-1:0]          idx_r, idx_nxt;
  logic                                out_valid_r;
  logic signed [mcpg_pkg::POINT_W-1:0] px_r, py_r, px_nxt, py_nxt;
  logic        [mcpg_pkg::COLOR_W-1:0] col_r, col_nxt;
  logic                                last_r, last_nxt;
  logic                                fin_r;
  logic                                load;
  logic                                idx_end;
  logic signed [mcpg_pkg::POINT_W-1:0] cx_e, cy_e, x_e, y_e, ax, ay;

  assign load    = q_not_empty && (!out_valid_r || out_chan.ready);
  assign idx_end = (idx_r == mcpg_pkg::IDX_W'(mcpg_pkg::POINTS_PER_STEP - 1));
  assign q_pop   = load && (head_job.fin || idx_end);

  always_comb begin
    cx_e = {head_job.cx[mcpg_pkg::COORD_W-1], head_job.cx};
    cy_e = {head_job.cy[mcpg_pkg::COORD_W-1], head_job.cy};
    x_e  = {head_job.x[mcpg_pkg::COORD_W-1], head_job.x};
    y_e  = {2'b00, head_job.y};
    // upper four points swap the roles of x and y
    ax   = idx_r[2] ? y_e : x_e;
    ay   = idx_r[2] ? x_e : y_e;
    if (head_job.fin) begin
      px_nxt   = '0;
      py_nxt   = '0;
      col_nxt  = '0;
      last_nxt = 1'b1;
    end else begin
      px_nxt   = idx_r[1] ? cx_e - ax : cx_e + ax;
      py_nxt   = idx_r[0] ? cy_e + ay : cy_e - ay;
      col_nxt  = head_job.color;
      last_nxt = idx_end;
    end
    if (q_pop) begin
      idx_nxt = '0;
    end else if (load) begin
      idx_nxt = idx_r + 1'b1;
    end else begin
      idx_nxt = idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      px_r   <= px_nxt;
      py_r   <= py_nxt;
      col_r  <= col_nxt;
      last_r <= last_nxt;
      fin_r  <= head_job.fin;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.point_x      = px_r;
  assign out_chan.point_y      = py_r;
  assign out_chan.point_color  = col_r;
  assign out_chan.last_of_step = last_r;
  assign out_chan.finished     = fin_r;

endmodule

// File: src/midpoint_circle_point_generator_top.sv
// ----------------------------------------------------------------------------
// midpoint_circle_point_generator_top
// midpoint circle rasteriser emitting eight mirrored points per step
//
// in_chan takes requests: kind start latches centre, radius and colour and
// gives no output; kind step gives the eight mirrored points of the current
// position, the eighth flagged last_of_step, or once the circle is complete
// (or none was started) a single point with finished and last_of_step set.
// out_chan delivers one point per cycle through a registered output stage
// while out_chan.ready is high and a job is queued. a step request is taken
// by the front iteration and queued; its first point passes the queue slot
// and then the output register, and the rest follow one per cycle while
// out_chan.ready stays high. the single output register sets the step rate.
// the front keeps accepting while the two-entry job queue has room, so it
// runs ahead of the output by up to two steps.
// when out_chan.ready is low the output register holds its point and the
// queue fills, after which in_chan.ready drops.
// synchronous active-low reset clears the circle state, the queue and the
// output valid; no circle is active after reset.
// ----------------------------------------------------------------------------
module midpoint_circle_point_generator_top (
  input  logic        clk,
  input  logic        rst_n,
  mcpg_in_if.sink     in_chan,
  mcpg_out_if.source  out_chan
);

  logic           q_full;
  logic           q_push;
  logic           q_pop;
  logic           q_not_empty;
  mcpg_pkg::job_t q_job;
  mcpg_pkg::job_t head_job;

  mcpg_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_job   (q_job)
  );

  mcpg_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_job  (q_job),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head_job  (head_job)
  );

  mcpg_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .head_job    (head_job),
    .q_pop       (q_pop),
    .out_chan    (out_chan)
  );

endmodule

// File: dv/tb_midpoint_circle_point_generator_top.sv
// ----------------------------------------------------------------------------
// tb_midpoint_circle_point_generator_top
// self-checking bench for the midpoint circle point generator
//
// queued start and step requests driven onto the request channel, a model of
// the circle iteration predicting the points and finished markers, and every
// point checked field by field against the oldest prediction
// directed part: extreme centres and radii, radius zero and one, steps with
// no circle; then random circles under random stalls on both sides, with one
// long output hold-off that backs the block up until it refuses requests
// ----------------------------------------------------------------------------
module tb_midpoint_circle_point_generator_top;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RADIUS_CAP  = 16383;
  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 64;

  typedef struct {
    logic               kind;
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    logic [13:0]        radius;
    logic [31:0]        color;
  } circle_req_t;

  typedef struct packed {
    logic signed [16:0] px;
    logic signed [16:0] py;
    logic [31:0]        color;
    logic               last;
    logic               fin;
  } plot_point_t;

  logic clk;
  logic rst_n;

  mcpg_in_if  in_if ();
  mcpg_out_if out_if ();

  midpoint_circle_point_generator_top u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  circle_req_t pending_reqs[$];
  plot_point_t expected_points[$];
  circle_req_t next_req;

  int send_idle_pct;
  int recv_idle_pct;
  int reqs_queued;
  int starts_taken;
  int steps_taken;
  int points_seen;
  int finish_seen;
  int err_count;
  int hold_left;
  bit hold_done;
  int stall_cycles;

  // circle iteration state
  bit          circ_active;
  int          cur_x;
  int          cur_y;
  int          step_x;
  int          step_y;
  int          decision;
  int          org_x;
  int          org_y;
  int          diam;
  logic [31:0] held_col;

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.kind = mcpg_pkg::KIND_START;
    in_if.center_x = '0;
    in_if.center_y = '0;
    in_if.radius = '0;
    in_if.color = '0;
    out_if.ready = 1'b0;
  end

  always #2 clk = ~clk;

  function automatic void expect_point(int px, int py, logic [31:0] col, logic last,
                                       logic fin);
    plot_point_t p;
    p.px = px[16:0];
    p.py = py[16:0];
    p.color = col;
    p.last = last;
    p.fin = fin;
    expected_points.push_back(p);
  endfunction

  function automatic void predict_request(logic kind, logic signed [15:0] cx,
                                          logic signed [15:0] cy, logic [13:0] rad,
                                          logic [31:0] col);
    int r;
    if (kind == mcpg_pkg::KIND_START) begin
      r = rad;
      if (r > RADIUS_CAP) r = RADIUS_CAP;
      org_x = cx;
      org_y = cy;
      held_col = col;
      diam = 2 * r;
      cur_x = r - 1;
      cur_y = 0;
      step_x = 1;
      step_y = 1;
      decision = 1 - diam;
      circ_active = 1'b1;
      starts_taken++;
    end else begin
      steps_taken++;
      if (!circ_active || cur_x < cur_y) begin
        circ_active = 1'b0;
        expect_point(0, 0, '0, 1'b1, 1'b1);
      end else begin
        expect_point(org_x + cur_x, org_y - cur_y, held_col, 1'b0, 1'b0);
        expect_point(org_x + cur_x, org_y + cur_y, held_col, 1'b0, 1'b0);
        expect_point(org_x - cur_x, org_y - cur_y, held_col, 1'b0, 1'b0);
        expect_point(org_x - cur_x, org_y + cur_y, held_col, 1'b0, 1'b0);
        expect_point(org_x + cur_y, org_y - cur_x, held_col, 1'b0, 1'b0);
        expect_point(org_x + cur_y, org_y + cur_x, held_col, 1'b0, 1'b0);
        expect_point(org_x - cur_y, org_y - cur_x, held_col, 1'b0, 1'b0);
        expect_point(org_x - cur_y, org_y + cur_x, held_col, 1'b1, 1'b0);
        if (decision <= 0) begin
          cur_y += 1;
          decision += step_y;
          step_y += 2;
        end
        if (decision > 0) begin
          cur_x -= 1;
          step_x += 2;
          decision += step_x - diam;
        end
      end
    end
  endfunction

  function automatic void check_point(plot_point_t want);
    if (out_if.point_x !== want.px) begin
      $error("point_x: expected %0d, got %0d", want.px, out_if.point_x);
      err_count++;
    end
    if (out_if.point_y !== want.py) begin
      $error("point_y: expected %0d, got %0d", want.py, out_if.point_y);
      err_count++;
    end
    if (out_if.point_color !== want.color) begin
      $error("point_color: expected %08h, got %08h", want.color, out_if.point_color);
      err_count++;
    end
    if (out_if.last_of_step !== want.last) begin
      $error("last_of_step: expected %0b, got %0b", want.last, out_if.last_of_step);
      err_count++;
    end
    if (out_if.finished !== want.fin) begin
      $error("finished: expected %0b, got %0b", want.fin, out_if.finished);
      err_count++;
    end
  endfunction

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_if.ready) begin
      if (in_if.valid) begin
        predict_request(in_if.kind, in_if.center_x, in_if.center_y, in_if.radius,
                        in_if.color);
      end
      if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_req = pending_reqs.pop_front();
        in_if.valid <= 1'b1;
        in_if.kind <= next_req.kind;
        in_if.center_x <= next_req.cx;
        in_if.center_y <= next_req.cy;
        in_if.radius <= next_req.radius;
        in_if.color <= next_req.color;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // point monitor and output back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_points.size() == 0) begin
          $error("unexpected point: x %0d y %0d finished %0b", out_if.point_x,
                 out_if.point_y, out_if.finished);
          err_count++;
        end else begin
          check_point(expected_points.pop_front());
        end
        if (out_if.finished) finish_seen++;
        else points_seen++;
      end
      if (hold_left != 0) begin
        out_if.ready <= 1'b0;
        hold_left <= hold_left - 1;
      end else if (!hold_done && points_seen >= 150) begin
        out_if.ready <= 1'b0;
        hold_left <= HOLD_CYCLES;
        hold_done <= 1'b1;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // watchdog on handshake progress
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
        $display("tb_midpoint_circle_point_generator_top: errors");
        $finish;
      end
    end
  end

  task automatic add_req(logic kind, logic signed [15:0] cx, logic signed [15:0] cy,
                         logic [13:0] rad, logic [31:0] col);
    circle_req_t q;
    q.kind = kind;
    q.cx = cx;
    q.cy = cy;
    q.radius = rad;
    q.color = col;
    pending_reqs.push_back(q);
    reqs_queued++;
  endtask

  task automatic add_step();
    // fields other than kind are ignored on a step, so fill them with noise
    add_req(mcpg_pkg::KIND_STEP, 16'($urandom), 16'($urandom), 14'($urandom), $urandom);
  endtask

  task automatic add_steps(int n);
    repeat (n) add_step();
  endtask

  task automatic add_random_circle();
    int sel;
    int r;
    int n;
    sel = $urandom_range(99);
    if (sel < 8) begin
      // lone step or lone start
      if ($urandom_range(1) != 0) add_step();
      else add_req(mcpg_pkg::KIND_START, 16'($urandom), 16'($urandom), 14'($urandom),
                   $urandom);
      return;
    end
    if (sel < 80) r = $urandom_range(0, 24);
    else if (sel < 90) r = $urandom_range(25, 60);
    else r = $urandom_range(0, RADIUS_CAP);
    add_req(mcpg_pkg::KIND_START, 16'($urandom), 16'($urandom), 14'(r), $urandom);
    if (sel < 80 && $urandom_range(3) != 0) n = (r * 3) / 4 + 2 + $urandom_range(1);
    else n = $urandom_range(0, 6);
    add_steps(n);
  endtask

  task automatic fill_random(int n);
    int goal;
    goal = reqs_queued + n;
    while (reqs_queued < goal) add_random_circle();
  endtask

  task automatic wait_drain();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || in_if.valid || expected_points.size() != 0);
  endtask

  initial begin
    send_idle_pct = 33;
    recv_idle_pct = 79;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // step before any circle
    add_step();
    // radius zero finishes at once, then a step with no circle
    add_req(mcpg_pkg::KIND_START, 16'sh7fff, 16'sh8000, 14'd0, 32'hffff_ffff);
    add_steps(2);
    // radius one: one step of points, then finished
    add_req(mcpg_pkg::KIND_START, 16'sh8000, 16'sh7fff, 14'd1, 32'h0000_0000);
    add_steps(2);
    // largest radius at both corners, restarted mid circle
    add_req(mcpg_pkg::KIND_START, 16'sh8000, 16'sh8000, 14'h3fff, 32'ha5a5_5a5a);
    add_steps(3);
    add_req(mcpg_pkg::KIND_START, 16'sh7fff, 16'sh7fff, 14'h3fff, 32'h5a5a_a5a5);
    add_steps(2);
    // small circle run to the end and one step past it
    add_req(mcpg_pkg::KIND_START, 16'sh0000, 16'shffff, 14'd3, 32'h1234_5678);
    add_steps(5);
    fill_random(70);
    wait_drain();

    send_idle_pct = 79;
    recv_idle_pct = 33;
    fill_random(80);
    wait_drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    fill_random(80);
    wait_drain();

    repeat (20) @(negedge clk);
    $display("run: %0d requests (%0d starts, %0d steps), %0d points and %0d finish markers",
             reqs_queued, starts_taken, steps_taken, points_seen, finish_seen);
    $display("stalls on both sides plus one %0d-cycle output hold-off", HOLD_CYCLES);
    if (err_count == 0 && expected_points.size() == 0) begin
      $display("tb_midpoint_circle_point_generator_top: clean");
    end else begin
      if (expected_points.size() != 0)
        $error("%0d expected points never arrived", expected_points.size());
      $display("tb_midpoint_circle_point_generator_top: errors");
    end
    $finish;
  end

endmodule

// File: midpoint_circle_point_generator_top.f
src/mcpg_pkg.sv
src/mcpg_ifs.sv
src/mcpg_front.sv
src/mcpg_queue.sv
src/mcpg_back.sv
src/midpoint_circle_point_generator_top.sv
dv/tb_midpoint_circle_point_generator_top.sv
